FILE: rtl/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg
// Shared types and constants for the saliency map metrics accumulator.
// ----------------------------------------------------------------------------
package smma_pkg;

   localparam int LEVEL_W = 7;
   localparam int FLAG_W  = 8;
   localparam int FMB_W   = 14;
   localparam int TOTAL_W = 64;
   localparam int SUM_W   = 48;
   localparam int FRAME_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MB    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATIC_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ITEM,
      ST_PREP,
      ST_DIV,
      ST_DONE,
      ST_COMMIT,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_SHAPE,
      STATUS_VALUE,
      STATUS_SMALL
   } status_type;

   // Division jobs, in the order the sequencer runs them.
   typedef enum logic [3:0] {
      JOB_PROT,
      JOB_FALSE,
      JOB_FDR,
      JOB_CHG,
      JOB_GLYPH,
      JOB_SMALL,
      JOB_AVG_PROT,
      JOB_AVG_FALSE,
      JOB_AVG_FDR,
      JOB_AVG_CHG
   } job_type;

endpackage

FILE: rtl/saliency_map_metrics_accumulator_unit.sv
// ----------------------------------------------------------------------------
// saliency_map_metrics_accumulator_unit
// Per-frame saliency metrics: glyph recalls, protected fractions and change.
// ----------------------------------------------------------------------------
// A macroblock is accepted in ST_IDLE, then updated in ST_ITEM against the level
// RAM read; busy holds off a new one until that update. The last macroblock
// adds finalize time on one shared restoring divider of 64+FRACTION_BITS steps.
// For an OK frame the per-frame jobs run (the change job only for a compared
// static frame), then the commit, then the glyph and average jobs; a rejected
// frame goes straight to the commit, and while nothing is committed the strobe
// follows the commit, then goes idle. rsp_valid is high for exactly one cycle;
// the receiver cannot stall it. Synchronous reset clears all counters and totals;
// the level RAM is not cleared, entries are only read after being written.
// ----------------------------------------------------------------------------
module saliency_map_metrics_accumulator_unit
   import smma_pkg::*;
#(
   parameter int MAX_MACROBLOCKS = 8192,
   parameter int FRACTION_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // input transaction
   input  logic                      start,
   output logic                      busy,
   input  logic signed [7:0]         req_emphasis_level,
   input  logic [FLAG_W-1:0]         req_glyph_flag,
   input  logic [FLAG_W-1:0]         req_small_glyph_flag,
   input  logic [FLAG_W-1:0]         req_ui_flag,
   input  logic                      req_last_in_frame,
   // register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [FMB_W-1:0]          csr_data,
   // result transaction
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [FRAME_W-1:0]        rsp_frames_observed,
   output logic [FRACTION_BITS:0]    rsp_glyph_recall,
   output logic [FRACTION_BITS:0]    rsp_small_glyph_recall,
   output logic [FRACTION_BITS:0]    rsp_protected_fraction,
   output logic [FRACTION_BITS:0]    rsp_false_protected_fraction,
   output logic [FRACTION_BITS:0]    rsp_false_discovery_fraction,
   output logic                      rsp_change_observed,
   output logic [FRACTION_BITS:0]    rsp_change_fraction
);

   localparam int IDX_W  = (MAX_MACROBLOCKS > 1) ? $clog2(MAX_MACROBLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_MACROBLOCKS + 2);
   localparam int DEPTH  = 2 * MAX_MACROBLOCKS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DEN_W  = TOTAL_W;
   localparam int DW     = TOTAL_W + FRACTION_BITS;
   localparam int FRAC_W = FRACTION_BITS + 1;
   localparam int IT_W   = $clog2(DW + 1);
   localparam logic [DW-1:0]    ONE_DW  = DW'(1) << FRACTION_BITS;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MACROBLOCKS);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [FMB_W-1:0]   frame_mb_ff, frame_mb_in;
   logic               static_mode_ff, static_mode_in;
   logic [LEVEL_W-1:0] max_level_ff, max_level_in;
   logic               bank_ff, bank_in;
   logic               prev_valid_ff, prev_valid_in;
   logic [CNT_W-1:0]   item_index_ff, item_index_in;
   logic [CNT_W-1:0]   cnt_prot_ff, cnt_prot_in;
   logic [CNT_W-1:0]   cnt_false_ff, cnt_false_in;
   logic [CNT_W-1:0]   cnt_chg_ff, cnt_chg_in;
   logic [CNT_W-1:0]   pend_ff [4];
   logic [CNT_W-1:0]   pend_in [4];
   logic [1:0]         err_ff, err_in;
   logic [TOTAL_W-1:0] total_ff [4];
   logic [TOTAL_W-1:0] total_in [4];
   logic [SUM_W-1:0]   sum_ff [4];
   logic [SUM_W-1:0]   sum_in [4];
   logic [FRAME_W-1:0] compared_ff, compared_in;
   logic [FRAME_W-1:0] committed_ff, committed_in;

   // payload
   logic [7:0]         lvl_ff, lvl_in;
   logic [FLAG_W-1:0]  glyph_ff, glyph_in;
   logic [FLAG_W-1:0]  small_ff, small_in;
   logic [FLAG_W-1:0]  ui_ff, ui_in;
   logic               last_ff, last_in;
   status_type         status_ff, status_in;
   job_type            job_ff, job_in;
   logic [DEN_W:0]     rem_ff, rem_in;
   logic [DW-1:0]      quo_ff, quo_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [IT_W-1:0]    iter_ff, iter_in;
   logic [FRAC_W-1:0]  res_ff [6];
   logic [FRAC_W-1:0]  res_in [6];

   // ---------------------------------------------------------------------
   // Level store: two banks, current frame written, previous frame read
   // ---------------------------------------------------------------------
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [LEVEL_W-1:0] ram_rd_data;

   // Read the previous bank at the accept edge; data lands in ST_ITEM.
   assign ram_rd_addr = (bank_ff ? ADDR_W'(0) : ADDR_W'(MAX_MACROBLOCKS))
                        + ADDR_W'(item_index_ff[IDX_W-1:0]);
   assign ram_wr_addr = (bank_ff ? ADDR_W'(MAX_MACROBLOCKS) : ADDR_W'(0))
                        + ADDR_W'(item_index_ff[IDX_W-1:0]);

   smma_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (DEPTH)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (lvl_ff[LEVEL_W-1:0]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Macroblock decode
   // ---------------------------------------------------------------------
   logic             in_range, value_err, prot, glyph, small_glyph, ui;
   logic [1:0]       err_item;
   logic [CNT_W-1:0] idx_next;
   logic             shape_err;
   status_type       frame_status;

   always_comb begin
      in_range    = item_index_ff < MAX_CNT;
      prot        = |lvl_ff;
      glyph       = |glyph_ff;
      small_glyph = |small_ff;
      ui          = |ui_ff;
      value_err = lvl_ff[7] || (lvl_ff[LEVEL_W-1:0] > max_level_ff) ||
                  (|glyph_ff[FLAG_W-1:1]) || (|small_ff[FLAG_W-1:1]) ||
                  (|ui_ff[FLAG_W-1:1]);
      err_item[0] = err_ff[0] | value_err;
      err_item[1] = err_ff[1] | (in_range & small_glyph & ~glyph);
      // Stop counting one past the limit so oversize frames stay detectable.
      idx_next  = (item_index_ff <= MAX_CNT) ? item_index_ff + CNT_W'(1)
                                             : item_index_ff;
      shape_err = (frame_mb_ff == '0) ||
                  (32'(frame_mb_ff) > 32'(MAX_MACROBLOCKS)) ||
                  (32'(idx_next) != 32'(frame_mb_ff));
      if (shape_err) begin
         frame_status = STATUS_SHAPE;
      end else if (err_item[0]) begin
         frame_status = STATUS_VALUE;
      end else if (err_item[1]) begin
         frame_status = STATUS_SMALL;
      end else begin
         frame_status = STATUS_OK;
      end
   end

   // ---------------------------------------------------------------------
   // Shared divider: operand select and one restoring step per cycle
   // ---------------------------------------------------------------------
   logic [DW-1:0]     div_a;
   logic [DEN_W-1:0]  div_d;
   logic [DEN_W:0]    rem_sh;
   logic              rem_ge;
   logic [FRAC_W-1:0] quot;
   logic [2:0]        res_idx;
   logic              chg_enable;

   always_comb begin
      case (job_ff)
         JOB_PROT: begin
            div_a = DW'(cnt_prot_ff) << FRACTION_BITS;
            div_d = DEN_W'(frame_mb_ff);
         end
         JOB_FALSE: begin
            div_a = DW'(cnt_false_ff) << FRACTION_BITS;
            div_d = DEN_W'(frame_mb_ff);
         end
         JOB_FDR: begin
            div_a = DW'(cnt_false_ff) << FRACTION_BITS;
            div_d = (cnt_prot_ff > CNT_W'(1)) ? DEN_W'(cnt_prot_ff) : DEN_W'(1);
         end
         JOB_CHG: begin
            div_a = DW'(cnt_chg_ff) << FRACTION_BITS;
            div_d = DEN_W'(frame_mb_ff);
         end
         JOB_GLYPH: begin
            div_a = DW'(total_ff[1]) << FRACTION_BITS;
            div_d = total_ff[0];
         end
         JOB_SMALL: begin
            div_a = DW'(total_ff[3]) << FRACTION_BITS;
            div_d = total_ff[2];
         end
         JOB_AVG_PROT: begin
            div_a = DW'(sum_ff[0]);
            div_d = DEN_W'(committed_ff);
         end
         JOB_AVG_FALSE: begin
            div_a = DW'(sum_ff[1]);
            div_d = DEN_W'(committed_ff);
         end
         JOB_AVG_FDR: begin
            div_a = DW'(sum_ff[2]);
            div_d = DEN_W'(committed_ff);
         end
         JOB_AVG_CHG: begin
            div_a = DW'(sum_ff[3]);
            div_d = DEN_W'(compared_ff);
         end
         default: begin
            div_a = '0;
            div_d = '0;
         end
      endcase
      rem_sh = {rem_ff[DEN_W-1:0], quo_ff[DW-1]};
      rem_ge = rem_sh >= {1'b0, den_ff};
      // Zero divisor gives zero; quotient clamps to 1.0.
      if (den_ff == '0) begin
         quot = '0;
      end else if (quo_ff > ONE_DW) begin
         quot = ONE_DW[FRAC_W-1:0];
      end else begin
         quot = quo_ff[FRAC_W-1:0];
      end
      res_idx    = 3'(job_ff - JOB_GLYPH);
      chg_enable = static_mode_ff & prev_valid_ff;
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   logic [FRAME_W-1:0] committed_next;

   always_comb begin
      committed_next = committed_ff;
      if (status_ff == STATUS_OK && committed_ff != '1) begin
         committed_next = committed_ff + FRAME_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ITEM;
            end
         end
         ST_ITEM: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (frame_status == STATUS_OK) begin
               state_in = ST_PREP;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_PREP: begin
            if (job_ff == JOB_CHG && !chg_enable) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (iter_ff == IT_W'(DW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (job_ff == JOB_CHG) begin
               state_in = ST_COMMIT;
            end else if (job_ff == JOB_AVG_CHG) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_COMMIT: begin
            if (committed_next == '0) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs and datapath next values
   // ---------------------------------------------------------------------
   logic [TOTAL_W:0] total_add [4];
   logic [SUM_W:0]   sum_add;

   always_comb begin
      busy      = state_ff != ST_IDLE;
      csr_ready = state_ff == ST_IDLE;
      ram_we    = (state_ff == ST_ITEM) && in_range;
      rsp_valid = state_ff == ST_RESP;

      rsp_status                   = status_ff;
      rsp_frames_observed          = committed_ff;
      rsp_glyph_recall             = res_ff[0];
      rsp_small_glyph_recall       = res_ff[1];
      rsp_protected_fraction       = res_ff[2];
      rsp_false_protected_fraction = res_ff[3];
      rsp_false_discovery_fraction = res_ff[4];
      rsp_change_observed          = compared_ff != '0;
      rsp_change_fraction          = res_ff[5];
   end

   always_comb begin
      frame_mb_in    = frame_mb_ff;
      static_mode_in = static_mode_ff;
      max_level_in   = max_level_ff;
      bank_in        = bank_ff;
      prev_valid_in  = prev_valid_ff;
      item_index_in  = item_index_ff;
      cnt_prot_in    = cnt_prot_ff;
      cnt_false_in   = cnt_false_ff;
      cnt_chg_in     = cnt_chg_ff;
      err_in         = err_ff;
      compared_in    = compared_ff;
      committed_in   = committed_ff;
      lvl_in         = lvl_ff;
      glyph_in       = glyph_ff;
      small_in       = small_ff;
      ui_in          = ui_ff;
      last_in        = last_ff;
      status_in      = status_ff;
      job_in         = job_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      den_in         = den_ff;
      iter_in        = iter_ff;
      sum_add        = {1'b0, sum_ff[0]};
      for (int i = 0; i < 4; i++) begin
         pend_in[i]   = pend_ff[i];
         total_in[i]  = total_ff[i];
         sum_in[i]    = sum_ff[i];
         total_add[i] = {1'b0, total_ff[i]} + (TOTAL_W + 1)'(pend_ff[i]);
      end
      for (int i = 0; i < 6; i++) begin
         res_in[i] = res_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            // capture the transaction
            if (start) begin
               lvl_in   = req_emphasis_level;
               glyph_in = req_glyph_flag;
               small_in = req_small_glyph_flag;
               ui_in    = req_ui_flag;
               last_in  = req_last_in_frame;
            end
         end
         ST_ITEM: begin
            err_in        = err_item;
            item_index_in = idx_next;
            if (in_range) begin
               if (!err_item[1]) begin
                  pend_in[0] = pend_ff[0] + CNT_W'(glyph);
                  pend_in[1] = pend_ff[1] + CNT_W'(prot & glyph);
                  pend_in[2] = pend_ff[2] + CNT_W'(small_glyph);
                  pend_in[3] = pend_ff[3] + CNT_W'(prot & small_glyph);
               end
               cnt_prot_in  = cnt_prot_ff + CNT_W'(prot);
               cnt_false_in = cnt_false_ff + CNT_W'(prot & ~glyph & ~ui);
               if (prev_valid_ff && lvl_ff[LEVEL_W-1:0] != ram_rd_data) begin
                  cnt_chg_in = cnt_chg_ff + CNT_W'(1);
               end
            end
            status_in = frame_status;
            job_in    = JOB_PROT;
         end
         ST_PREP: begin
            // load the divider
            rem_in  = '0;
            quo_in  = div_a;
            den_in  = div_d;
            iter_in = '0;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_in  = {quo_ff[DW-2:0], rem_ge};
            iter_in = iter_ff + IT_W'(1);
         end
         ST_DONE: begin
            if (job_ff <= JOB_CHG) begin
               // accumulate the per-frame fraction, saturating
               sum_add = {1'b0, sum_ff[job_ff[1:0]]} + (SUM_W + 1)'(quot);
               sum_in[job_ff[1:0]] = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end else begin
               res_in[res_idx] = quot;
            end
            job_in = job_type'(job_ff + 4'd1);
         end
         ST_COMMIT: begin
            if (status_ff == STATUS_OK || status_ff == STATUS_SMALL) begin
               for (int i = 0; i < 4; i++) begin
                  total_in[i] = total_add[i][TOTAL_W] ? '1 : total_add[i][TOTAL_W-1:0];
               end
            end
            if (status_ff == STATUS_OK && static_mode_ff) begin
               if (prev_valid_ff && compared_ff != '1) begin
                  compared_in = compared_ff + FRAME_W'(1);
               end
               bank_in       = ~bank_ff;
               prev_valid_in = 1'b1;
            end
            committed_in = committed_next;
            for (int i = 0; i < 6; i++) begin
               res_in[i] = '0;
            end
            job_in = JOB_GLYPH;
         end
         ST_RESP: begin
            // drop the frame state
            item_index_in = '0;
            err_in        = '0;
            cnt_prot_in   = '0;
            cnt_false_in  = '0;
            cnt_chg_in    = '0;
            for (int i = 0; i < 4; i++) begin
               pend_in[i] = '0;
            end
         end
         default: begin
         end
      endcase

      // register writes arrive only while idle
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_MB: begin
               frame_mb_in   = csr_data;
               prev_valid_in = 1'b0;
            end
            CSR_STATIC_MODE: begin
               static_mode_in = csr_data[0];
            end
            CSR_MAX_LEVEL: begin
               max_level_in = csr_data[LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_mb_ff    <= '0;
         static_mode_ff <= 1'b0;
         max_level_ff   <= LEVEL_W'(7);
         bank_ff        <= 1'b0;
         prev_valid_ff  <= 1'b0;
         item_index_ff  <= '0;
         cnt_prot_ff    <= '0;
         cnt_false_ff   <= '0;
         cnt_chg_ff     <= '0;
         err_ff         <= '0;
         compared_ff    <= '0;
         committed_ff   <= '0;
         for (int i = 0; i < 4; i++) begin
            pend_ff[i]  <= '0;
            total_ff[i] <= '0;
            sum_ff[i]   <= '0;
         end
      end else begin
         state_ff       <= state_in;
         frame_mb_ff    <= frame_mb_in;
         static_mode_ff <= static_mode_in;
         max_level_ff   <= max_level_in;
         bank_ff        <= bank_in;
         prev_valid_ff  <= prev_valid_in;
         item_index_ff  <= item_index_in;
         cnt_prot_ff    <= cnt_prot_in;
         cnt_false_ff   <= cnt_false_in;
         cnt_chg_ff     <= cnt_chg_in;
         err_ff         <= err_in;
         compared_ff    <= compared_in;
         committed_ff   <= committed_in;
         for (int i = 0; i < 4; i++) begin
            pend_ff[i]  <= pend_in[i];
            total_ff[i] <= total_in[i];
            sum_ff[i]   <= sum_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      glyph_ff  <= glyph_in;
      small_ff  <= small_in;
      ui_ff     <= ui_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      job_ff    <= job_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      iter_ff   <= iter_in;
      for (int i = 0; i < 6; i++) begin
         res_ff[i] <= res_in[i];
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_ok_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |-> (rsp_frames_observed != '0))
      else $error("committed frame not counted");

   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> prev_valid_ff)
      else $error("bank flipped without a valid previous frame");

endmodule

FILE: rtl/smma_ram.sv
// ----------------------------------------------------------------------------
// smma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
